FILE: rtl/infix_to_postfix_converter_unit_macros.svh
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ITP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/itp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int VAL_W       = 32;

	// input token kinds
	localparam logic [3:0] TK_OPERAND = 4'd0;
	localparam logic [3:0] TK_PLUS    = 4'd1;
	localparam logic [3:0] TK_MINUS   = 4'd2;
	localparam logic [3:0] TK_TIMES   = 4'd3;
	localparam logic [3:0] TK_DIVIDE  = 4'd4;
	localparam logic [3:0] TK_NEGATE  = 4'd5;
	localparam logic [3:0] TK_ABS     = 4'd6;
	localparam logic [3:0] TK_OPEN    = 4'd7;
	localparam logic [3:0] TK_CLOSE   = 4'd8;
	localparam logic [3:0] TK_END     = 4'd9;

	// output kinds and stack entry codes
	localparam logic [2:0] OK_OPERAND = 3'd0;
	localparam logic [2:0] OK_STATUS  = 3'd7;
	localparam logic [2:0] SE_OPEN    = 3'd7;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_PAREN    = 2'd2;

	typedef struct packed {
		logic [2:0]       kind;
		logic [VAL_W-1:0] value;
		logic [1:0]       err;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/itp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface itp_tok_if import itp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [3:0]       token_kind;
	logic [VAL_W-1:0] operand_value;

	modport source (output valid, token_kind, operand_value, input ready);
	modport sink (input valid, token_kind, operand_value, output ready);
endinterface

interface itp_res_if import itp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       out_kind;
	logic [VAL_W-1:0] out_value;
	logic             last_of_run;
	logic [1:0]       error_code;

	modport source (output valid, out_kind, out_value, last_of_run, error_code, input ready);
	modport sink (input valid, out_kind, out_value, last_of_run, error_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/infix_to_postfix_converter_unit.sv
// operand or push onto a full stack: result held in the pending register, sent out in flush
// negate, abs or open with room on the stack: pushed at accept, no result, unit stays idle
// binary, close and end tokens: stack popped in their state, then flush; one token in flight
// output stalls hold the sequencer; results pass through a pending register for the last flag
// reset clears the stack count, sequencer and handshake; stack entries are not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_unit_macros.svh"

module infix_to_postfix_converter_unit import itp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	itp_tok_if.sink    tok,
	itp_res_if.source  res
);

	typedef enum logic [2:0] {S_IDLE, S_BIN, S_CLOSE, S_END, S_FLUSH} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       kind_q;
	logic             found_q;
	res_t             pnd_q;
	logic             pnd_vld_q;
	res_t             out_q;
	logic             out_last_q;
	logic             out_vld_q;
	logic [2:0]       stack_q [STACK_DEPTH];

	logic             out_free;
	logic             adv;
	logic             tok_acc;
	logic [CNT_W-1:0] cnt_m1;
	logic [2:0]       top;
	logic             full;
	logic             push_en;
	logic [2:0]       push_val;

	function automatic logic [1:0] prio(input logic [2:0] k);
		logic [1:0] p;
		p = 2'd0;
		if (k == TK_PLUS[2:0] || k == TK_MINUS[2:0])
			p = 2'd1;
		else if (k >= TK_TIMES[2:0] && k <= TK_ABS[2:0])
			p = 2'd2;
		return p;
	endfunction

	assign out_free = !out_vld_q || res.ready;
	assign adv      = !pnd_vld_q || out_free;
	assign tok_acc  = tok.valid && tok.ready;
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign top      = stack_q[cnt_m1[IDX_W-1:0]];
	assign full     = (cnt_q == CNT_W'(STACK_DEPTH));

	assign tok.ready       = (state_q == S_IDLE);
	assign res.valid       = out_vld_q;
	assign res.out_kind    = out_q.kind;
	assign res.out_value   = out_q.value;
	assign res.error_code  = out_q.err;
	assign res.last_of_run = out_last_q;

	// push decode shared by the idle accept and the binary operator step
	always_comb begin
		push_en  = 1'b0;
		push_val = tok.token_kind[2:0];
		if (tok_acc && !full &&
		    (tok.token_kind == TK_NEGATE || tok.token_kind == TK_ABS ||
		     tok.token_kind == TK_OPEN)) begin
			push_en = 1'b1;
		end else if (state_q == S_BIN && adv && !full &&
		             !(cnt_q != '0 && prio(top) >= prio(kind_q))) begin
			push_en  = 1'b1;
			push_val = kind_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en)
			stack_q[cnt_q[IDX_W-1:0]] <= push_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			kind_q     <= '0;
			found_q    <= 1'b0;
			pnd_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
			out_last_q <= 1'b0;
			pnd_q      <= '0;
			out_q      <= '0;
		end else begin
			if (res.ready)
				out_vld_q <= 1'b0;
			if (push_en)
				cnt_q <= cnt_q + CNT_W'(1);

			unique case (state_q)
				S_IDLE: begin
					if (tok_acc) begin
						kind_q  <= tok.token_kind[2:0];
						found_q <= 1'b0;
						priority case (1'b1)
							tok.token_kind == TK_OPERAND: begin
								pnd_q     <= '{kind: OK_OPERAND, value: tok.operand_value,
								               err: ERR_NONE};
								pnd_vld_q <= 1'b1;
								state_q   <= S_FLUSH;
							end
							tok.token_kind >= TK_PLUS && tok.token_kind <= TK_DIVIDE:
								state_q <= S_BIN;
							tok.token_kind >= TK_NEGATE && tok.token_kind <= TK_OPEN: begin
								if (full) begin
									pnd_q     <= '{kind: OK_STATUS, value: '0,
									               err: ERR_OVERFLOW};
									pnd_vld_q <= 1'b1;
									state_q   <= S_FLUSH;
								end
							end
							tok.token_kind == TK_CLOSE:
								state_q <= S_CLOSE;
							tok.token_kind == TK_END:
								state_q <= S_END;
							default: ;
						endcase
					end
				end
				S_BIN: begin
					if (adv) begin
						if (pnd_vld_q) begin
							out_q      <= pnd_q;
							out_last_q <= 1'b0;
							out_vld_q  <= 1'b1;
						end
						pnd_vld_q <= 1'b0;
						if (cnt_q != '0 && prio(top) >= prio(kind_q)) begin
							pnd_q     <= '{kind: top, value: '0, err: ERR_NONE};
							pnd_vld_q <= 1'b1;
							cnt_q     <= cnt_m1;
						end else begin
							if (full) begin
								pnd_q     <= '{kind: OK_STATUS, value: '0, err: ERR_OVERFLOW};
								pnd_vld_q <= 1'b1;
							end else begin
								pnd_vld_q <= pnd_vld_q;
							end
							state_q <= S_FLUSH;
						end
						// pending item stays only when nothing new replaces it
						if (!(cnt_q != '0 && prio(top) >= prio(kind_q)) && !full) begin
							out_vld_q <= out_vld_q && !res.ready;
						end
					end
				end
				S_CLOSE: begin
					if (adv) begin
						if (cnt_q == '0) begin
							if (pnd_vld_q) begin
								out_q      <= pnd_q;
								out_last_q <= 1'b0;
								out_vld_q  <= 1'b1;
							end
							pnd_q     <= '{kind: OK_STATUS, value: '0, err: ERR_PAREN};
							pnd_vld_q <= 1'b1;
							state_q   <= S_FLUSH;
						end else begin
							cnt_q <= cnt_m1;
							if (top == SE_OPEN) begin
								state_q <= S_FLUSH;
							end else begin
								if (pnd_vld_q) begin
									out_q      <= pnd_q;
									out_last_q <= 1'b0;
									out_vld_q  <= 1'b1;
								end
								pnd_q     <= '{kind: top, value: '0, err: ERR_NONE};
								pnd_vld_q <= 1'b1;
							end
						end
					end
				end
				S_END: begin
					if (adv) begin
						if (cnt_q == '0) begin
							if (found_q) begin
								if (pnd_vld_q) begin
									out_q      <= pnd_q;
									out_last_q <= 1'b0;
									out_vld_q  <= 1'b1;
								end
								pnd_q     <= '{kind: OK_STATUS, value: '0, err: ERR_PAREN};
								pnd_vld_q <= 1'b1;
							end
							state_q <= S_FLUSH;
						end else begin
							cnt_q <= cnt_m1;
							if (top == SE_OPEN) begin
								found_q <= 1'b1;
							end else begin
								if (pnd_vld_q) begin
									out_q      <= pnd_q;
									out_last_q <= 1'b0;
									out_vld_q  <= 1'b1;
								end
								pnd_q     <= '{kind: top, value: '0, err: ERR_NONE};
								pnd_vld_q <= 1'b1;
							end
						end
					end
				end
				S_FLUSH: begin
					if (!pnd_vld_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q      <= pnd_q;
						out_last_q <= 1'b1;
						out_vld_q  <= 1'b1;
						pnd_vld_q  <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ITP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH), "stack count past depth")
	`ITP_ASSERT_NOW(a_idle_empty, state_q == S_IDLE, !pnd_vld_q, "pending result left at idle")
	`ITP_ASSERT_NOW(a_err_status, res.valid && res.error_code != ERR_NONE,
		res.out_kind == OK_STATUS && res.last_of_run, "error on a non-status result")
	`ITP_ASSERT_NEXT(a_flush_last, state_q == S_FLUSH && pnd_vld_q && out_free,
		res.valid && res.last_of_run, "flush did not deliver the last result")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import itp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_TOKENS  = 220;
	localparam int MAX_REPORTS    = 10;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct {
		logic [3:0]       kind;
		logic [VAL_W-1:0] value;
	} token_t;

	typedef struct {
		logic [2:0]       kind;
		logic [VAL_W-1:0] value;
		logic             last;
		logic [1:0]       err;
	} postfix_out_t;

	// shunting-yard predictor plus the queue of postfix outputs it expects
	class postfix_scoreboard;
		logic [2:0]   op_stack [STACK_DEPTH];
		int           depth_cnt;
		postfix_out_t expected_q [$];
		int           mismatches;

		function new();
			depth_cnt  = 0;
			mismatches = 0;
		endfunction

		function int rank_of(logic [3:0] k);
			case (k)
				TK_PLUS, TK_MINUS: return 1;
				TK_TIMES, TK_DIVIDE, TK_NEGATE, TK_ABS: return 2;
				default: return 0;
			endcase
		endfunction

		function void emit(logic [2:0] kind, logic [VAL_W-1:0] value, logic [1:0] err);
			postfix_out_t o;
			o.kind  = kind;
			o.value = value;
			o.last  = 1'b0;
			o.err   = err;
			expected_q.push_back(o);
		endfunction

		function logic [2:0] pop_op();
			depth_cnt--;
			return op_stack[depth_cnt];
		endfunction

		function void push_op(logic [2:0] e);
			if (depth_cnt >= STACK_DEPTH) begin
				emit(OK_STATUS, '0, ERR_OVERFLOW);
			end else begin
				op_stack[depth_cnt] = e;
				depth_cnt++;
			end
		endfunction

		function void note_token(logic [3:0] kind, logic [VAL_W-1:0] value);
			int         first;
			bit         found;
			logic [2:0] e;
			first = expected_q.size();
			found = 1'b0;
			case (kind)
				TK_OPERAND: emit(OK_OPERAND, value, ERR_NONE);
				TK_PLUS, TK_MINUS, TK_TIMES, TK_DIVIDE: begin
					// left-associative: pop while top ranks at least as high
					while (depth_cnt > 0 &&
							rank_of({1'b0, op_stack[depth_cnt-1]}) >= rank_of(kind)) begin
						e = pop_op();
						emit(e, '0, ERR_NONE);
					end
					push_op(kind[2:0]);
				end
				TK_NEGATE, TK_ABS: push_op(kind[2:0]);
				TK_OPEN: push_op(SE_OPEN);
				TK_CLOSE: begin
					while (depth_cnt > 0) begin
						e = pop_op();
						if (e == SE_OPEN) begin
							found = 1'b1;
							break;
						end
						emit(e, '0, ERR_NONE);
					end
					if (!found)
						emit(OK_STATUS, '0, ERR_PAREN);
				end
				TK_END: begin
					while (depth_cnt > 0) begin
						e = pop_op();
						if (e == SE_OPEN)
							found = 1'b1;
						else
							emit(e, '0, ERR_NONE);
					end
					if (found)
						emit(OK_STATUS, '0, ERR_PAREN);
				end
				default: ;
			endcase
			if (expected_q.size() > first)
				expected_q[expected_q.size()-1].last = 1'b1;
		endfunction

		function void check_result(logic [2:0] kind, logic [VAL_W-1:0] value,
				logic last, logic [1:0] err);
			postfix_out_t x;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: kind=%0d value=%h last=%b err=%0d",
						kind, value, last, err);
				return;
			end
			x = expected_q.pop_front();
			if (x.kind !== kind || x.value !== value || x.last !== last || x.err !== err) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: expected kind=%0d value=%h last=%b err=%0d, got kind=%0d value=%h last=%b err=%0d",
						x.kind, x.value, x.last, x.err, kind, value, last, err);
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	itp_tok_if tok_ch ();
	itp_res_if res_ch ();

	infix_to_postfix_converter_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok_ch),
		.res    (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	postfix_scoreboard sb = new();
	token_t            token_q [$];
	bit                quiet;
	int                token_cnt;
	int                idle_cycles = 0;

	logic [3:0] binary_ops [4] = '{TK_PLUS, TK_MINUS, TK_TIMES, TK_DIVIDE};
	logic [3:0] push_ops   [3] = '{TK_OPEN, TK_NEGATE, TK_ABS};

	function automatic void add_tok(logic [3:0] kind, logic [VAL_W-1:0] value = $urandom);
		token_t t;
		t.kind  = kind;
		t.value = value;
		token_q.push_back(t);
	endfunction

	// well-formed infix expression of bounded nesting
	function automatic void gen_expr(int depth);
		int pick;
		pick = (depth == 0) ? 0 : $urandom_range(0, 4);
		case (pick)
			0: add_tok(TK_OPERAND);
			1, 2: begin
				gen_expr(depth - 1);
				add_tok(binary_ops[$urandom_range(0, 3)]);
				gen_expr(depth - 1);
			end
			3: begin
				add_tok(TK_OPEN);
				gen_expr(depth - 1);
				add_tok(TK_CLOSE);
			end
			default: begin
				add_tok(push_ops[$urandom_range(1, 2)]);
				gen_expr(depth - 1);
			end
		endcase
	endfunction

	task automatic send_token(token_t t);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			tok_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok_ch.valid         <= 1'b1;
		tok_ch.token_kind    <= t.kind;
		tok_ch.operand_value <= t.value;
		@(posedge clk);
		while (!tok_ch.ready)
			@(posedge clk);
		sb.note_token(t.kind, t.value);
		if (t.kind <= TK_END)
			token_cnt++;
	endtask

	task automatic send_all();
		foreach (token_q[i])
			send_token(token_q[i]);
		token_q.delete();
	endtask

	// hold the sender off until every expected output has been seen
	task automatic drain_results();
		tok_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		int     mode;
		int     pos;
		token_t t;
		tok_ch.valid         <= 1'b0;
		tok_ch.token_kind    <= TK_OPERAND;
		tok_ch.operand_value <= '0;
		quiet     = 1'b0;
		token_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// precedence and left associativity
		add_tok(TK_OPERAND, '0);
		add_tok(TK_PLUS);
		add_tok(TK_OPERAND, '1);
		add_tok(TK_TIMES);
		add_tok(TK_OPERAND);
		add_tok(TK_MINUS);
		add_tok(TK_OPERAND);
		add_tok(TK_DIVIDE);
		add_tok(TK_OPERAND);
		add_tok(TK_END);
		// unary operators around a parenthesized operand
		add_tok(TK_NEGATE);
		add_tok(TK_ABS);
		add_tok(TK_OPEN);
		add_tok(TK_OPERAND);
		add_tok(TK_CLOSE);
		add_tok(TK_END);
		// unmatched close on empty stack, then after an operator
		add_tok(TK_CLOSE);
		add_tok(TK_OPERAND);
		add_tok(TK_PLUS);
		add_tok(TK_CLOSE);
		// empty parens, then open left at end
		add_tok(TK_OPEN);
		add_tok(TK_CLOSE);
		add_tok(TK_OPEN);
		add_tok(TK_END);
		// undefined kinds are ignored
		add_tok(4'd12);
		add_tok(4'd15);
		send_all();
		drain_results();

		while (token_cnt < RANDOM_TOKENS) begin
			quiet = ($urandom_range(0, 4) == 0);
			mode  = $urandom_range(0, 9);
			case (mode)
				0, 1, 2, 3, 4, 5: begin
					gen_expr($urandom_range(0, 3));
					add_tok(TK_END);
				end
				6: begin
					// broken expression: stray paren, sometimes no end
					gen_expr($urandom_range(1, 3));
					t.kind  = $urandom_range(0, 1) ? TK_OPEN : TK_CLOSE;
					t.value = $urandom;
					pos     = $urandom_range(0, token_q.size());
					token_q.insert(pos, t);
					if ($urandom_range(0, 1))
						add_tok(TK_END);
				end
				7: begin
					repeat ($urandom_range(1, 6))
						add_tok(4'($urandom_range(0, 15)));
				end
				8: begin
					// deep nesting to reach a full stack
					repeat ($urandom_range(13, 19))
						add_tok(push_ops[$urandom_range(0, 2)]);
					add_tok(TK_OPERAND);
					add_tok(binary_ops[$urandom_range(0, 3)]);
					add_tok(TK_OPERAND);
					if ($urandom_range(0, 1))
						add_tok(TK_CLOSE);
					add_tok(TK_END);
				end
				default: begin
					drain_results();
					gen_expr($urandom_range(1, 3));
					add_tok(TK_END);
				end
			endcase
			send_all();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// result side with random backpressure
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
			sb.check_result(res_ch.out_kind, res_ch.out_value, res_ch.last_of_run,
				res_ch.error_code);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((tok_ch.valid && tok_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
